[rtl/core/sldq_pkg.sv]
// sldq_pkg: shared types and constants for the sorted double-ended queue
// no dependencies; used by every module under rtl/core
package sldq_pkg;

	// field widths
	localparam int KEY_W   = 32;
	localparam int CMD_W   = 2;
	localparam int CNT_W   = 5;
	localparam int DEPTH_DEF = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RM_MIN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RM_MAX  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RM_KEY  = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic compare;
		logic execute;
	} sldq_ctl_t;

endpackage

[rtl/core/sldq_ctrl.sv]
// sldq_ctrl: accept / compare / execute sequencer and output beat valid
// depends on sldq_pkg
module sldq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sldq_pkg::sldq_ctl_t ctl
);
	import sldq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       can_fin;
	logic       acc;

	// result slot free or being drained this cycle
	assign can_fin  = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_EXE) && can_fin));
	assign acc      = in_valid && !in_stall;

	assign ctl.load    = acc;
	assign ctl.compare = (state_q == ST_CMP);
	assign ctl.execute = (state_q == ST_EXE) && can_fin;
	assign out_valid   = out_valid_q;

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					if (can_fin) state_q <= acc ? ST_CMP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.execute) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/sldq_dp.sv]
// sldq_dp: sorted cell chain with per-cell compare, shift update and result registers
// depends on sldq_pkg; driven by sldq_ctrl commands
module sldq_dp #(
	parameter int DEPTH = sldq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sldq_pkg::sldq_ctl_t               ctl,
	input  logic [sldq_pkg::CMD_W-1:0]        cmd,
	input  logic signed [sldq_pkg::KEY_W-1:0] key,
	output logic                              ok,
	output logic signed [sldq_pkg::KEY_W-1:0] removed_value,
	output logic [sldq_pkg::CNT_W-1:0]        count,
	output logic                              is_empty
);
	import sldq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [KEY_W-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]        occ_q;
	logic [CW-1:0]           count_q;
	logic [CMD_W-1:0]        cmd_q;
	logic signed [KEY_W-1:0] key_q;

	logic [DEPTH-1:0]        less_s1;
	logic                    found_s1;
	logic signed [KEY_W-1:0] max_s1;

	logic                    ok_q;
	logic signed [KEY_W-1:0] removed_q;

	logic [DEPTH-1:0]        less_c;
	logic [DEPTH-1:0]        eq_c;
	logic [DEPTH-1:0]        last_c;
	logic [KEY_W-1:0]        max_c;
	logic signed [KEY_W-1:0] up_val [DEPTH];
	logic signed [KEY_W-1:0] ins_val [DEPTH];
	logic                    full;
	logic                    empty;

	assign full  = occ_q[DEPTH-1];
	assign empty = !occ_q[0];

	// per-cell compare against the latched key
	always_comb begin
		max_c = '0;
		for (int i = 0; i < DEPTH; i++) begin
			less_c[i] = occ_q[i] && (cell_q[i] < key_q);
			eq_c[i]   = occ_q[i] && (cell_q[i] == key_q);
			if (i == DEPTH - 1) last_c[i] = occ_q[i];
			else                last_c[i] = occ_q[i] && !occ_q[i+1];
			max_c = max_c | (cell_q[i] & {KEY_W{last_c[i]}});
		end
	end

	// neighbor values for shift down and sorted insert
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == DEPTH - 1) up_val[i] = cell_q[i];
			else                up_val[i] = cell_q[i+1];
			if (less_s1[i])     ins_val[i] = cell_q[i];
			else if (i == 0)    ins_val[i] = key_q;
			else if (less_s1[i-1]) ins_val[i] = key_q;
			else                ins_val[i] = cell_q[i-1];
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			key_q <= key;
		end
	end

	// compare stage
	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			less_s1  <= less_c;
			found_s1 <= |eq_c;
			max_s1   <= max_c;
		end
	end

	// cell chain update
	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			for (int i = 0; i < DEPTH; i++) begin
				case (cmd_q)
					CMD_INSERT: begin
						if (!full) cell_q[i] <= ins_val[i];
					end
					CMD_RM_MIN: begin
						if (!empty) cell_q[i] <= up_val[i];
					end
					CMD_RM_KEY: begin
						if (found_s1 && !less_s1[i]) cell_q[i] <= up_val[i];
					end
					default: begin
						cell_q[i] <= cell_q[i];
					end
				endcase
			end
		end
	end

	// occupancy and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else if (ctl.execute) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (!full) begin
						occ_q   <= {occ_q[DEPTH-2:0], 1'b1};
						count_q <= count_q + 1'b1;
					end
				end
				CMD_RM_MIN, CMD_RM_MAX: begin
					if (!empty) begin
						occ_q   <= {1'b0, occ_q[DEPTH-1:1]};
						count_q <= count_q - 1'b1;
					end
				end
				CMD_RM_KEY: begin
					if (found_s1) begin
						occ_q   <= {1'b0, occ_q[DEPTH-1:1]};
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			case (cmd_q)
				CMD_INSERT: begin
					ok_q      <= !full;
					removed_q <= '0;
				end
				CMD_RM_MIN: begin
					ok_q      <= !empty;
					removed_q <= empty ? '0 : cell_q[0];
				end
				CMD_RM_MAX: begin
					ok_q      <= !empty;
					removed_q <= empty ? '0 : max_s1;
				end
				default: begin
					ok_q      <= found_s1;
					removed_q <= found_s1 ? key_q : '0;
				end
			endcase
		end
	end

	assign ok            = ok_q;
	assign removed_value = removed_q;
	assign count         = CNT_W'(count_q);
	assign is_empty      = empty;

endmodule

[rtl/core/sorted_list_double_ended_queue.sv]
// sorted_list_double_ended_queue: top level of the sorted double-ended queue
// depends on sldq_pkg, sldq_ctrl and sldq_dp
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_stall    | cmd, key
//  out     | out_valid / out_stall  | ok, removed_value, count, is_empty
//
// every command passes a compare state, which checks the key against all cells at
// once, then an execute state, which updates the cell chain and loads the results.
// the next beat is taken in the cycle the current one executes.
// a result held by out_stall keeps the following item waiting in execute,
// and the input stays stalled until the held result is taken.
// reset empties the queue at once; cell contents need no clearing.
module sorted_list_double_ended_queue #(
	parameter int DEPTH = sldq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sldq_pkg::CMD_W-1:0]        cmd,
	input  logic signed [sldq_pkg::KEY_W-1:0] key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic signed [sldq_pkg::KEY_W-1:0] removed_value,
	output logic [sldq_pkg::CNT_W-1:0]        count,
	output logic                              is_empty
);
	import sldq_pkg::*;

	sldq_ctl_t ctl;

	// sequencer
	sldq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// cell chain and result registers
	sldq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.key           (key),
		.ok            (ok),
		.removed_value (removed_value),
		.count         (count),
		.is_empty      (is_empty)
	);

endmodule
